@@ src/gdd_pkg.sv @@
// ============================================================================
// gdd_pkg
// Shared widths, constants, command/status types and calendar helpers for
// the Gregorian date difference block.
// ============================================================================
`default_nettype none

package gdd_pkg;

    // Calendar configuration
    localparam int EPOCH_YEAR = 1970;
    localparam int YEAR_BITS  = 12;

    // Field widths
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 21;
    localparam int WDAY_W  = 3;

    // Year divided by four, and leap-year counts, fit in this width
    localparam int QUART_W = YEAR_BITS - 2;

    // Day number since the epoch, largest possible year included
    localparam int DAYNUM_W = $clog2((2 ** YEAR_BITS - EPOCH_YEAR) * 366 + 1);
    localparam int MOD_W    = DAYNUM_W + 1;
    localparam int SUB_W    = (DAYNUM_W + 1 > DIFF_W) ? DAYNUM_W + 1 : DIFF_W;

    // Leap years in 1 .. EPOCH_YEAR-1
    localparam int EPOCH_LEAPS = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                               + (EPOCH_YEAR - 1) / 400;

    // x / 25 as (x * 5243) >> 17, exact for x below 2^14
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;
    localparam int DIV25_W     = QUART_W + DIV25_SHIFT;

    localparam int MOD7_GROUPS = (MOD_W + 2) / 3;

    localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(12);

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input transfer
        logic sel_b;     // work on date B (else A)
        logic do_year;   // year stage: offsets, leap counts
        logic do_days;   // day stage: day number, validity
        logic load_out;  // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register full and not being taken
    } t_status;

    function automatic logic [QUART_W-1:0] div25(input logic [QUART_W-1:0] x);
        logic [DIV25_W-1:0] p;
        p = DIV25_W'(x) * DIV25_W'(DIV25_MUL);
        return p[DIV25_SHIFT +: QUART_W];
    endfunction

    // Leap years in 1 .. n
    function automatic logic [QUART_W-1:0] leaps_upto(input logic [YEAR_BITS-1:0] n);
        logic [QUART_W-1:0] q;
        logic [QUART_W-1:0] c;
        q = n[YEAR_BITS-1:2];
        c = div25(q);
        return q - c + (c >> 2);
    endfunction

    // Days before the first of month m in a common year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MON_FEB) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = DAY_W'(30);
        end else begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

    // x mod 7 by folding octal digits (8 == 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7(input logic [MOD_W-1:0] x);
        logic [3*MOD7_GROUPS-1:0] xp;
        logic [7:0]               s1;
        logic [3:0]               s2;
        logic [3:0]               s3;
        xp = (3 * MOD7_GROUPS)'(x);
        s1 = 8'd0;
        for (int i = 0; i < MOD7_GROUPS; i++) begin
            s1 = s1 + 8'(xp[3*i +: 3]);
        end
        s2 = 4'(s1[7:6]) + 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        if (s3 >= 4'd7) begin
            s3 = s3 - 4'd7;
        end
        return s3[WDAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/gregorian_date_difference.sv @@
// ============================================================================
// gregorian_date_difference
// Signed day count between two Gregorian dates, with validity, leap flag
// and weekday index of the first date.
//
// Takes dates A and B (year, month, day) in one input transfer and returns
// one result transfer: o_day_difference = days(A) - days(B) as a signed
// 21-bit count, o_weekday_a = (days of A since 1970-01-01 + 1) mod 7,
// o_valid_a/o_valid_b, and o_leap_a. A date is valid from 1970 onward with
// month 1..12 and day within the month (leap rule of 4, 100 and 400).
// Results tied to an invalid date read zero: difference when either date is
// invalid, weekday and leap flag when A is invalid. One item is processed at
// a time; from the input transfer, the item runs through the year stage and
// day stage for A, then for B, then result assembly into the output
// register, and no new item is taken before it is done. The result
// sits in an output register, so the next input is accepted while a result
// waits; the block only holds in its last step when a second result is ready
// and the first has not been taken. Latency is set by the one shared
// day-number unit (one 365x multiply per date) and the sequencer around it.
// ============================================================================
`default_nettype none

module gregorian_date_difference (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [gdd_pkg::YEAR_BITS-1:0]     i_year_a,
    input  wire logic [gdd_pkg::MONTH_W-1:0]       i_month_a,
    input  wire logic [gdd_pkg::DAY_W-1:0]         i_day_a,
    input  wire logic [gdd_pkg::YEAR_BITS-1:0]     i_year_b,
    input  wire logic [gdd_pkg::MONTH_W-1:0]       i_month_b,
    input  wire logic [gdd_pkg::DAY_W-1:0]         i_day_b,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [gdd_pkg::DIFF_W-1:0]      o_day_difference,
    output logic [gdd_pkg::WDAY_W-1:0]             o_weekday_a,
    output logic                                   o_valid_a,
    output logic                                   o_valid_b,
    output logic                                   o_leap_a
);

    gdd_pkg::t_cmd    w_cmd;     // sequencer commands
    gdd_pkg::t_status w_status;  // back-pressure from the output register

    // Sequencer: idle -> year/day for A -> year/day for B -> load result
    gdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: capture, day-number unit, output register
    gdd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_year_a         (i_year_a),
        .i_month_a        (i_month_a),
        .i_day_a          (i_day_a),
        .i_year_b         (i_year_b),
        .i_month_b        (i_month_b),
        .i_day_b          (i_day_b),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_day_difference (o_day_difference),
        .o_weekday_a      (o_weekday_a),
        .o_valid_a        (o_valid_a),
        .o_valid_b        (o_valid_b),
        .o_leap_a         (o_leap_a)
    );

endmodule

`default_nettype wire

@@ src/gdd_ctrl.sv @@
// ============================================================================
// gdd_ctrl
// Sequencer: captures a transfer, runs year and day stages for A then B,
// then hands the result to the output register.
// ============================================================================
`default_nettype none

module gdd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire gdd_pkg::t_status i_status,
    output gdd_pkg::t_cmd        o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_YEAR_A = 6'b000010,
        ST_DAYS_A = 6'b000100,
        ST_YEAR_B = 6'b001000,
        ST_DAYS_B = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_YEAR_A;
                end
            end
            ST_YEAR_A: begin
                o_cmd.do_year = 1'b1;
                n_state       = ST_DAYS_A;
            end
            ST_DAYS_A: begin
                o_cmd.do_days = 1'b1;
                n_state       = ST_YEAR_B;
            end
            ST_YEAR_B: begin
                o_cmd.sel_b   = 1'b1;
                o_cmd.do_year = 1'b1;
                n_state       = ST_DAYS_B;
            end
            ST_DAYS_B: begin
                o_cmd.sel_b   = 1'b1;
                o_cmd.do_days = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

@@ src/gdd_datapath.sv @@
// ============================================================================
// gdd_datapath
// Input capture, shared day-number unit (year stage, day stage), result
// assembly and the output register.
// ============================================================================
`default_nettype none

module gdd_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gdd_pkg::t_cmd                     i_cmd,
    output gdd_pkg::t_status                       o_status,
    input  wire logic [gdd_pkg::YEAR_BITS-1:0]     i_year_a,
    input  wire logic [gdd_pkg::MONTH_W-1:0]       i_month_a,
    input  wire logic [gdd_pkg::DAY_W-1:0]         i_day_a,
    input  wire logic [gdd_pkg::YEAR_BITS-1:0]     i_year_b,
    input  wire logic [gdd_pkg::MONTH_W-1:0]       i_month_b,
    input  wire logic [gdd_pkg::DAY_W-1:0]         i_day_b,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [gdd_pkg::DIFF_W-1:0]      o_day_difference,
    output logic [gdd_pkg::WDAY_W-1:0]             o_weekday_a,
    output logic                                   o_valid_a,
    output logic                                   o_valid_b,
    output logic                                   o_leap_a
);

    localparam int YB = gdd_pkg::YEAR_BITS;
    localparam int QW = gdd_pkg::QUART_W;
    localparam int DW = gdd_pkg::DAYNUM_W;

    // captured transfer
    logic [YB-1:0]                r_ya, r_yb;
    logic [gdd_pkg::MONTH_W-1:0]  r_ma, r_mb;
    logic [gdd_pkg::DAY_W-1:0]    r_da, r_db;

    // year stage
    logic [YB-1:0]                r_yoff;
    logic [QW-1:0]                r_leaps;
    logic                         r_leap;
    logic                         r_ge_epoch;

    // per-date results
    logic [DW-1:0]                r_na, r_nb;
    logic                         r_va, r_vb, r_leap_a;

    // output register
    logic                         r_out_valid;
    logic signed [gdd_pkg::DIFF_W-1:0] r_diff;
    logic [gdd_pkg::WDAY_W-1:0]   r_wday;
    logic                         r_ova, r_ovb, r_oleap;

    logic [YB-1:0]                w_y;
    logic [gdd_pkg::MONTH_W-1:0]  w_m;
    logic [gdd_pkg::DAY_W-1:0]    w_d;
    logic [QW-1:0]                w_q;
    logic [QW-1:0]                w_cq;
    logic [QW+4:0]                w_q25;
    logic                         w_leap;
    logic [YB+8:0]                w_yprod;
    logic [DW-1:0]                w_dn;
    logic                         w_ok;
    logic [gdd_pkg::SUB_W-1:0]    w_sub;

    assign w_y = i_cmd.sel_b ? r_yb : r_ya;
    assign w_m = i_cmd.sel_b ? r_mb : r_ma;
    assign w_d = i_cmd.sel_b ? r_db : r_da;

    // leap: divisible by 4, and not by 100 unless by 400
    assign w_q    = w_y[YB-1:2];
    assign w_cq   = gdd_pkg::div25(w_q);
    assign w_q25  = (QW+5)'(w_cq) * (QW+5)'(25);
    assign w_leap = (w_y[1:0] == 2'b00) && ((w_q25 != (QW+5)'(w_q)) || (w_cq[1:0] == 2'b00));

    assign w_yprod = (YB+9)'(r_yoff) * (YB+9)'(365);

    assign w_ok = r_ge_epoch
               && (w_m >= gdd_pkg::MON_JAN) && (w_m <= gdd_pkg::MON_DEC)
               && (w_d != '0) && (w_d <= gdd_pkg::month_len(w_m, r_leap));

    assign w_dn = DW'(w_yprod) + DW'(r_leaps) - DW'(gdd_pkg::EPOCH_LEAPS)
                + DW'(gdd_pkg::month_start(w_m))
                + DW'((w_m > gdd_pkg::MON_FEB) && r_leap)
                + DW'(w_d) - DW'(1);

    assign w_sub = gdd_pkg::SUB_W'(r_na) - gdd_pkg::SUB_W'(r_nb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ya <= i_year_a;
            r_ma <= i_month_a;
            r_da <= i_day_a;
            r_yb <= i_year_b;
            r_mb <= i_month_b;
            r_db <= i_day_b;
        end
        if (i_cmd.do_year) begin
            r_yoff     <= w_y - YB'(gdd_pkg::EPOCH_YEAR);
            r_leaps    <= gdd_pkg::leaps_upto(w_y - YB'(1));
            r_leap     <= w_leap;
            r_ge_epoch <= (w_y >= YB'(gdd_pkg::EPOCH_YEAR));
        end
        if (i_cmd.do_days) begin
            if (i_cmd.sel_b) begin
                r_nb <= w_dn;
                r_vb <= w_ok;
            end else begin
                r_na     <= w_dn;
                r_va     <= w_ok;
                r_leap_a <= r_leap;
            end
        end
        if (i_cmd.load_out) begin
            r_ova   <= r_va;
            r_ovb   <= r_vb;
            r_oleap <= r_va && r_leap_a;
            r_wday  <= r_va ? gdd_pkg::mod7(gdd_pkg::MOD_W'(r_na) + gdd_pkg::MOD_W'(1)) : '0;
            r_diff  <= (r_va && r_vb) ? signed'(w_sub[gdd_pkg::DIFF_W-1:0]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_day_difference = r_diff;
    assign o_weekday_a      = r_wday;
    assign o_valid_a        = r_ova;
    assign o_valid_b        = r_ovb;
    assign o_leap_a         = r_oleap;

endmodule

`default_nettype wire

@@ src/gdd_checker.sv @@
// ============================================================================
// gdd_checker
// Port-level checks for the date difference block, bound to the top level.
// ============================================================================
`default_nettype none

module gdd_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic signed [gdd_pkg::DIFF_W-1:0] o_day_difference,
    input  wire logic [gdd_pkg::WDAY_W-1:0]        o_weekday_a,
    input  wire logic                              o_valid_a,
    input  wire logic                              o_valid_b,
    input  wire logic                              o_leap_a
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_day_difference)
                                      && $stable(o_weekday_a))
        else $error("stalled result changed");

    // one item in flight: input is held off right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // invalid A zeroes everything derived from A
    a_inv_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_a |-> o_day_difference == '0 && o_weekday_a == '0
                                      && !o_leap_a)
        else $error("invalid A gave nonzero result");

    // invalid B zeroes the difference
    a_inv_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_b |-> o_day_difference == '0)
        else $error("invalid B gave nonzero difference");

    // weekday index is in range
    a_wday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weekday_a <= gdd_pkg::WDAY_W'(6))
        else $error("weekday out of range");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);

`default_nettype wire

@@ sim/gdd_date_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// gdd_date_checker
// Watches both channels of the date difference block. Every input transfer
// is turned into an expected result. Every result transfer is compared
// with the oldest expected result, field by field.
// ============================================================================

module gdd_date_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [gdd_pkg::YEAR_BITS-1:0]        i_year_a,
    input  logic [gdd_pkg::MONTH_W-1:0]          i_month_a,
    input  logic [gdd_pkg::DAY_W-1:0]            i_day_a,
    input  logic [gdd_pkg::YEAR_BITS-1:0]        i_year_b,
    input  logic [gdd_pkg::MONTH_W-1:0]          i_month_b,
    input  logic [gdd_pkg::DAY_W-1:0]            i_day_b,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [gdd_pkg::DIFF_W-1:0]    i_day_difference,
    input  logic [gdd_pkg::WDAY_W-1:0]           i_weekday_a,
    input  logic                                 i_valid_a,
    input  logic                                 i_valid_b,
    input  logic                                 i_leap_a,
    output int                                   o_mismatch_count,
    output int                                   o_pending_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [gdd_pkg::DIFF_W-1:0] day_diff;
        logic [gdd_pkg::WDAY_W-1:0]        weekday;
        logic                              valid_a;
        logic                              valid_b;
        logic                              leap_a;
    } t_date_result;

    t_date_result expected_results[$];
    int           mismatch_total = 0;
    int           pending_total  = 0;

    assign o_mismatch_count = mismatch_total;
    assign o_pending_count  = pending_total;

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        if (m == gdd_pkg::MON_FEB) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == gdd_pkg::MON_APR || m == gdd_pkg::MON_JUN || m == gdd_pkg::MON_SEP
            || m == gdd_pkg::MON_NOV) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit real_date(input int y, input int m, input int d);
        if (y < gdd_pkg::EPOCH_YEAR) return 1'b0;
        if (m < gdd_pkg::MON_JAN || m > gdd_pkg::MON_DEC) return 1'b0;
        return (d >= 1) && (d <= month_days(y, m));
    endfunction

    function automatic int leap_years_through(input int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // days since EPOCH_YEAR-01-01, date must be real
    function automatic int epoch_day(input int y, input int m, input int d);
        int n;
        n = 365 * (y - gdd_pkg::EPOCH_YEAR) + leap_years_through(y - 1)
          - leap_years_through(gdd_pkg::EPOCH_YEAR - 1);
        for (int k = gdd_pkg::MON_JAN; k < m; k++) begin
            n += month_days(y, k);
        end
        return n + d - 1;
    endfunction

    function automatic t_date_result predict_date_result(
        input logic [gdd_pkg::YEAR_BITS-1:0] ya, input logic [gdd_pkg::MONTH_W-1:0] ma,
        input logic [gdd_pkg::DAY_W-1:0] da, input logic [gdd_pkg::YEAR_BITS-1:0] yb,
        input logic [gdd_pkg::MONTH_W-1:0] mb, input logic [gdd_pkg::DAY_W-1:0] db);
        t_date_result r;
        int           na;
        int           nb;
        r = '0;
        r.valid_a = real_date(int'(ya), int'(ma), int'(da));
        r.valid_b = real_date(int'(yb), int'(mb), int'(db));
        if (r.valid_a) begin
            na        = epoch_day(int'(ya), int'(ma), int'(da));
            r.weekday = gdd_pkg::WDAY_W'((na + 1) % 7);
            r.leap_a  = leap_year(int'(ya));
            if (r.valid_b) begin
                nb         = epoch_day(int'(yb), int'(mb), int'(db));
                r.day_diff = gdd_pkg::DIFF_W'(na - nb);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_date_result exp,
                                   input t_date_result act);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT) begin
            $display("%0t: %s: diff exp %0d got %0d, weekday exp %0d got %0d,",
                     $realtime, what, exp.day_diff, act.day_diff, exp.weekday,
                     act.weekday);
            $display("    valid_a exp %0b got %0b, valid_b exp %0b got %0b, leap exp %0b got %0b",
                     exp.valid_a, act.valid_a, exp.valid_b, act.valid_b,
                     exp.leap_a, act.leap_a);
        end
    endtask

    always @(posedge i_clk) begin
        t_date_result seen;
        t_date_result exp;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_date_result(i_year_a, i_month_a,
                    i_day_a, i_year_b, i_month_b, i_day_b));
            end
            if (i_out_valid && !i_out_stall) begin
                seen.day_diff = i_day_difference;
                seen.weekday  = i_weekday_a;
                seen.valid_a  = i_valid_a;
                seen.valid_b  = i_valid_b;
                seen.leap_a   = i_leap_a;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", '0, seen);
                end else begin
                    exp = expected_results.pop_front();
                    if (seen.day_diff !== exp.day_diff || seen.weekday !== exp.weekday ||
                        seen.valid_a !== exp.valid_a || seen.valid_b !== exp.valid_b ||
                        seen.leap_a !== exp.leap_a) begin
                        report_mismatch("result mismatch", exp, seen);
                    end
                end
            end
            pending_total = expected_results.size();
        end
    end

endmodule

@@ sim/gregorian_date_difference_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// gregorian_date_difference_tb
// Drives date pairs into the date difference block and lets a checker
// compare every result against its own calendar arithmetic. A directed set
// covers the calendar edge cases, then about 2000 random pairs follow, most
// of them plausible dates with random content, the rest broken or noise.
// Both sides idle at random; one long receiver hold-off backs the block up.
// ============================================================================

module gregorian_date_difference_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PAIRS  = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;

    localparam int EPOCH = gdd_pkg::EPOCH_YEAR;
    localparam int JAN   = gdd_pkg::MON_JAN;
    localparam int FEB   = gdd_pkg::MON_FEB;
    localparam int APR   = gdd_pkg::MON_APR;
    localparam int JUN   = gdd_pkg::MON_JUN;
    localparam int DEC   = gdd_pkg::MON_DEC;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [gdd_pkg::YEAR_BITS-1:0]     year_a    = '0;
    logic [gdd_pkg::MONTH_W-1:0]       month_a   = '0;
    logic [gdd_pkg::DAY_W-1:0]         day_a     = '0;
    logic [gdd_pkg::YEAR_BITS-1:0]     year_b    = '0;
    logic [gdd_pkg::MONTH_W-1:0]       month_b   = '0;
    logic [gdd_pkg::DAY_W-1:0]         day_b     = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [gdd_pkg::DIFF_W-1:0] day_difference;
    logic [gdd_pkg::WDAY_W-1:0]        weekday_a;
    logic                              valid_a;
    logic                              valid_b;
    logic                              leap_a;

    int mismatch_count;
    int pending_count;
    int cycle_count      = 0;
    // set by the stimulus, consumed by the receiver process
    int long_hold_cycles = 0;
    // when set, neither side idles
    bit no_idle          = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    gregorian_date_difference dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_year_a         (year_a),
        .i_month_a        (month_a),
        .i_day_a          (day_a),
        .i_year_b         (year_b),
        .i_month_b        (month_b),
        .i_day_b          (day_b),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_day_difference (day_difference),
        .o_weekday_a      (weekday_a),
        .o_valid_a        (valid_a),
        .o_valid_b        (valid_b),
        .o_leap_a         (leap_a)
    );

    gdd_date_checker date_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_year_a         (year_a),
        .i_month_a        (month_a),
        .i_day_a          (day_a),
        .i_year_b         (year_b),
        .i_month_b        (month_b),
        .i_day_b          (day_b),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_day_difference (day_difference),
        .i_weekday_a      (weekday_a),
        .i_valid_a        (valid_a),
        .i_valid_b        (valid_b),
        .i_leap_a         (leap_a),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // ------------------------------------------------------------------------
    // Sender: starts and ends at a falling edge. Valid stays high between
    // back-to-back transfers, so it is never dropped and raised in one step.
    // ------------------------------------------------------------------------
    task automatic offer_dates(input int ya, input int ma, input int da,
                               input int yb, input int mb, input int db);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        year_a   <= gdd_pkg::YEAR_BITS'(ya);
        month_a  <= gdd_pkg::MONTH_W'(ma);
        day_a    <= gdd_pkg::DAY_W'(da);
        year_b   <= gdd_pkg::YEAR_BITS'(yb);
        month_b  <= gdd_pkg::MONTH_W'(mb);
        day_b    <= gdd_pkg::DAY_W'(db);
        in_valid <= 1'b1;
        // hold the payload until a rising edge sees the transfer
        do begin
            @(posedge clk);
        end while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    // Plausible date: leans on the epoch, century years and the top of the
    // year range; days past 28 show up often enough to hit month ends.
    task automatic pick_date(output int y, output int m, output int d);
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(EPOCH, EPOCH + 10);
            1:       y = 100 * int'($urandom_range(20, 40)) + int'($urandom_range(0, 8)) - 4;
            2:       y = $urandom_range(4080, 4095);
            default: y = $urandom_range(EPOCH, 4095);
        endcase
        m = $urandom_range(JAN, DEC);
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    endtask

    // break one field of a date so that it cannot be real
    task automatic spoil_date(inout int y, inout int m, inout int d);
        case ($urandom_range(0, 2))
            0:       y = $urandom_range(0, EPOCH - 1);
            1:       m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
            default: d = 0;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver: after each result transfer it draws how many cycles to stall.
    // A requested long hold-off is counted here, independent of the sender.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                stall_left = no_idle ? 0 : $urandom_range(0, 19);
            end
            @(negedge clk);
            if (long_hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
                while (hold_left > 0) begin
                    @(negedge clk);
                    hold_left--;
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
        end
        $display("** gregorian_date_difference: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int ya, ma, da, yb, mb, db;
        int kind;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // epoch against itself, and the widest span in both directions
        offer_dates(EPOCH, JAN, 1, EPOCH, JAN, 1);
        offer_dates(4095, DEC, 31, EPOCH, JAN, 1);
        offer_dates(EPOCH, JAN, 1, 4095, DEC, 31);
        // all-zero and all-one fields
        offer_dates(0, 0, 0, 0, 0, 0);
        offer_dates(4095, 15, 31, 4095, 15, 31);
        // leap rules: 400-year leap, 100-year non-leap, ordinary non-leap
        offer_dates(2000, FEB, 29, 1999, 3, 1);
        offer_dates(2100, FEB, 29, 2000, JAN, 1);
        offer_dates(2400, FEB, 29, 2100, FEB, 28);
        offer_dates(2023, FEB, 29, 2023, FEB, 28);
        offer_dates(4092, FEB, 29, 4095, FEB, 29);
        // year before the epoch
        offer_dates(1969, DEC, 31, EPOCH, JAN, 1);
        // month zero, month past December, day zero, day past month end
        offer_dates(2024, 0, 10, 2024, JAN, 10);
        offer_dates(2024, 13, 10, 2024, JAN, 10);
        offer_dates(2024, 5, 0, 2024, 5, 1);
        offer_dates(2024, APR, 31, 2024, APR, 30);
        // only B invalid: weekday and leap flag still describe A
        offer_dates(2024, 7, 4, 2024, JUN, 31);
        // only A invalid
        offer_dates(1800, JAN, 1, 2020, JAN, 1);
        // A earlier than B, A later than B, and equal dates
        offer_dates(2024, FEB, 29, 2024, 3, 1);
        offer_dates(2999, 6, 15, 3000, 6, 15);
        offer_dates(2024, DEC, 31, 2024, JAN, 1);
        offer_dates(1971, JAN, 1, EPOCH, DEC, 31);
        offer_dates(EPOCH, JAN, 31, EPOCH, JAN, 31);

        // sender pauses until the block has handed back everything
        in_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);

        // long receiver hold-off while transfers keep coming back to back:
        // the output register fills and the block stalls its input
        long_hold_cycles = LONG_HOLD;
        no_idle          = 1'b1;
        for (int i = 0; i < 12; i++) begin
            pick_date(ya, ma, da);
            pick_date(yb, mb, db);
            offer_dates(ya, ma, da, yb, mb, db);
        end
        no_idle = 1'b0;

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            // every fourth stretch of 150 pairs runs with no idling at all
            no_idle = ((i / 150) % 4 == 3);
            if (i == RANDOM_PAIRS / 2) begin
                in_valid <= 1'b0;
                wait (pending_count == 0);
                @(negedge clk);
            end
            kind = $urandom_range(0, 19);
            pick_date(ya, ma, da);
            pick_date(yb, mb, db);
            if (kind < 3) begin
                // same year, so small differences and both signs
                yb = ya;
            end else if (kind >= 15 && kind < 17) begin
                spoil_date(ya, ma, da);
            end else if (kind == 17) begin
                spoil_date(yb, mb, db);
            end else if (kind >= 18) begin
                ya = $urandom_range(0, 4095);
                ma = $urandom_range(0, 15);
                da = $urandom_range(0, 31);
                yb = $urandom_range(0, 4095);
                mb = $urandom_range(0, 15);
                db = $urandom_range(0, 31);
            end
            offer_dates(ya, ma, da, yb, mb, db);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("** gregorian_date_difference: PASSED **");
        end else begin
            $display("** gregorian_date_difference: FAILED **");
        end
        $finish;
    end

endmodule

@@ gregorian_date_difference.f @@
src/gdd_pkg.sv
src/gdd_ctrl.sv
src/gdd_datapath.sv
src/gregorian_date_difference.sv
src/gdd_checker.sv
sim/gdd_date_checker.sv
sim/gregorian_date_difference_tb.sv
